FILE: hdl/lru_pkg.sv
// Shared constants, command struct and controller state type for the
// LRU page replacement block. No dependencies.
package lru_pkg;

    localparam int FRAMES_DEF    = 4;
    localparam int PAGE_BITS_DEF = 16;
    localparam int PAGE_W        = 16;
    localparam int CFG_W         = 3;
    localparam int COUNT_W       = 16;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [CFG_W-1:0]   LIMIT_RESET = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } lru_state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } lru_cmd_t;

endpackage

FILE: hdl/lru_page_replacement.sv
// Top level of the LRU page replacement block: joins controller and datapath.
// Depends on lru_pkg, lru_ctrl and lru_dp.
//
// Usage: each transfer on the slave stream (s_tvalid/s_tready/s_tdata) carries
// one requested page number. The block looks it up among the resident pages,
// all compared in parallel, and then updates the recency list: a hit moves the
// page to the most recent place, a miss inserts it there and, when the frames
// in use are full, evicts the least recently used page.
// Each request yields exactly one transfer on the master stream, carrying the
// hit flag, the eviction report and the saturating page-fault count.
// The block takes no new request until the last one is through its steps:
// accept, parallel lookup into a registered match index, then the list shift
// and result load. m_tvalid is registered and is set by the result load.
// The result sits in an output register; the next request is accepted and
// looked up while it waits, and only the list update stalls until the
// receiver takes the waiting result, so backpressure holds the block in place.
// Users write the frame limit (cfg_we/cfg_wdata) only when idle; not enforced.
// Reset empties the recency list, clears the fault count and sets the frame
// limit to three; no clearing pass is needed.
module lru_page_replacement
    import lru_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] page
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] hit, [1] evicted_valid,
                                              // [17:2] evicted_page,
                                              // [33:18] miss_total, [39:34] zero
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata  // frame_limit
);

    lru_cmd_t            cmd;
    logic                hit;
    logic                evicted_valid;
    logic [PAGE_W-1:0]   evicted_page;
    logic [COUNT_W-1:0]  miss_total;

    lru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lru_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .page          (s_tdata[PAGE_W-1:0]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .miss_total    (miss_total)
    );

    // Result fields packed from the lowest bit up, padded to whole bytes.
    assign m_tdata = {
        (OUT_TDATA_W - 2 - PAGE_W - COUNT_W)'(0),
        miss_total,
        evicted_page,
        evicted_valid,
        hit
    };

endmodule

FILE: hdl/lru_ctrl.sv
// Controller for the LRU page replacement block: sequences load, lookup and
// update of one request and owns the result valid flag. Uses lru_pkg.
module lru_ctrl
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output lru_cmd_t cmd
);

    lru_state_t state_reg;
    lru_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // The list update waits until the output register can take the result.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // A new result must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while stalled");

    // An accepted request always proceeds to the lookup step.
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    // A waiting result stays offered until the receiver takes it.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while the receiver stalled");

endmodule

FILE: hdl/lru_dp.sv
// Datapath for the LRU page replacement block: recency list, occupancy and
// fault counters, frame limit register and result register. Uses lru_pkg.
module lru_dp
    import lru_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lru_cmd_t               cmd,
    input  logic [PAGE_W-1:0]      page,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    output logic                   hit,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [COUNT_W-1:0]     miss_total
);

    localparam int CW    = $clog2(FRAMES + 1);
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LW    = (CW > CFG_W) ? CW : CFG_W;

    logic [PAGE_BITS-1:0] list_reg [FRAMES];
    logic [PAGE_BITS-1:0] list_next [FRAMES];
    logic [PAGE_BITS-1:0] page_reg;
    logic [CW-1:0]        occ_reg;
    logic [CW-1:0]        occ_next;
    logic [COUNT_W-1:0]   miss_reg;
    logic [COUNT_W-1:0]   miss_next;
    logic [CFG_W-1:0]     limit_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     pos_reg;

    logic                 out_hit_reg;
    logic                 out_ev_valid_reg;
    logic [PAGE_W-1:0]    out_ev_page_reg;
    logic [COUNT_W-1:0]   out_miss_reg;

    logic                 match_any;
    logic [IDX_W-1:0]     match_idx;
    logic [LW-1:0]        lim_eff;
    logic                 room;
    logic [CW-1:0]        occ_m1;
    logic [IDX_W-1:0]     ev_idx;
    logic [IDX_W-1:0]     shpos;
    logic                 evict;

    // Parallel compare against every occupied frame; the lowest index wins.
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if ((CW'(i) < occ_reg) && (list_reg[i] == page_reg))
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // A limit of zero behaves as one, and a limit above the built size as the size.
    always_comb
    begin
        priority if (limit_reg == '0)
        begin
            lim_eff = LW'(1);
        end
        else if (LW'(limit_reg) > LW'(FRAMES))
        begin
            lim_eff = LW'(FRAMES);
        end
        else
        begin
            lim_eff = LW'(limit_reg);
        end
    end

    always_comb
    begin
        room   = (LW'(occ_reg) < lim_eff);
        occ_m1 = occ_reg - CW'(1);
        ev_idx = occ_m1[IDX_W-1:0];
        evict  = !hit_reg && !room;
        priority if (hit_reg)
        begin
            shpos = pos_reg;
        end
        else if (room)
        begin
            shpos = occ_reg[IDX_W-1:0];
        end
        else
        begin
            shpos = ev_idx;
        end
    end

    // Entries above the shift position keep their place; the rest move down by one.
    always_comb
    begin
        list_next[0] = page_reg;
        for (int k = 1; k < FRAMES; k++)
        begin
            if (IDX_W'(k) <= shpos)
            begin
                list_next[k] = list_reg[k-1];
            end
            else
            begin
                list_next[k] = list_reg[k];
            end
        end
    end

    always_comb
    begin
        occ_next  = occ_reg;
        miss_next = miss_reg;
        if (!hit_reg)
        begin
            if (room)
            begin
                occ_next = occ_reg + CW'(1);
            end
            if (miss_reg != COUNT_MAX)
            begin
                miss_next = miss_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            miss_reg  <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                occ_reg  <= occ_next;
                miss_reg <= miss_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= PAGE_BITS'(page);
        end
        if (cmd.lookup)
        begin
            hit_reg <= match_any;
            pos_reg <= match_idx;
        end
        if (cmd.commit)
        begin
            list_reg         <= list_next;
            out_hit_reg      <= hit_reg;
            out_ev_valid_reg <= evict;
            out_ev_page_reg  <= evict ? PAGE_W'(list_reg[ev_idx]) : '0;
            out_miss_reg     <= miss_next;
        end
    end

    assign hit           = out_hit_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign miss_total    = out_miss_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(occ_reg) <= LW'(FRAMES))
        else $error("occupancy beyond frame count");

    a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (miss_reg >= $past(miss_reg)))
        else $error("fault counter went backwards");

    // A hit neither evicts nor counts a fault.
    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_reg) |=> (!out_ev_valid_reg && out_miss_reg == $past(miss_reg)))
        else $error("hit produced an eviction or a fault count");

endmodule
